[design/cbnd_pkg.sv]
package cbnd_pkg;

  // Field widths
  localparam int FREQ_W    = 32;
  localparam int RESP_W    = 32;
  localparam int NODE_W    = 12;
  localparam int CUR_W     = 9;
  localparam int DIV_W     = 8;
  localparam int KIND_W    = 2;
  localparam int VERB_W    = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 12;
  localparam int IN_DATA_W = 72;
  localparam int OUT_DATA_W = 56;

  // Divider: 12000 / f, 8-bit quotient
  localparam int DIVISOR_W = 14;
  localparam int DSR_W     = DIVISOR_W + DIV_W - 1;
  localparam logic [DIVISOR_W-1:0] FREQ_BASE = DIVISOR_W'(12000);
  localparam logic [FREQ_W-1:0]    FREQ_HIGH = FREQ_W'(12000);
  localparam logic [FREQ_W-1:0]    FREQ_LOW  = FREQ_W'(12000 / 255);
  localparam logic [DIV_W-1:0]     DIV_MAX   = 8'hFF;
  localparam logic [DIV_W-1:0]     DIV_FAST  = 8'h01;

  // Input selector
  localparam logic OP_REQUEST  = 1'b0;
  localparam logic OP_RESPONSE = 1'b1;

  // Result kinds
  localparam logic [KIND_W-1:0] K_VERB   = 2'd0;
  localparam logic [KIND_W-1:0] K_DONE   = 2'd1;
  localparam logic [KIND_W-1:0] K_FAILED = 2'd2;
  localparam logic [KIND_W-1:0] K_IGNORE = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OVERRIDE_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERRIDE_NODE   = 1'b1;

  // Codec verbs and parameters
  localparam logic [11:0] V_GET_PARAMS  = 12'hF00;
  localparam logic [11:0] V_SET_BEEP    = 12'h70A;
  localparam logic [7:0]  P_NODE_COUNT  = 8'h04;
  localparam logic [7:0]  P_GROUP_CAPS  = 8'h08;
  localparam logic [7:0]  P_WIDGET_CAPS = 8'h09;
  localparam int          GROUP_BEEP_BIT = 16;
  localparam logic [3:0]  WIDGET_BEEP   = 4'h7;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic commit;
  } cbnd_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_busy;
    logic out_free;
  } cbnd_sts_t;

  function automatic logic [VERB_W-1:0] make_verb(input logic [NODE_W-1:0] node,
                                                  input logic [11:0] verb,
                                                  input logic [7:0] param);
    make_verb = {node, verb, param};
  endfunction

endpackage

[design/codec_beep_node_discovery_core.sv]
// Channel  | Direction | Contents
// in_      | slave     | tuser: op; tdata: frequency, response_word, response_ok
// out_     | master    | tuser: kind; tdata: verb, beep_node, divider
// cfg_     | write     | index 0 override_enable, index 1 override_node
//
// One item at a time. A beep request whose frequency lies inside the divide
// range goes through capture, eight restoring-division steps in the
// divider unit, the controller seeing the divider go idle, and commit.
// Every other item goes through capture and commit.
// Reset (rst_n low, synchronous) clears the walk state, the override
// registers and the output valid flag; the block then waits for an item.
// A result waits in the output register while the next item is taken and
// worked on; that item commits only once the output register is free.
module codec_beep_node_discovery_core
  import cbnd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_wdata,
  // input items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] frequency, [63:32] response_word,
                                            // [64] response_ok, [71:65] zero
  input  logic                  in_tuser,   // [0] op
  // result items
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [31:0] verb, [43:32] beep_node,
                                            // [51:44] divider, [55:52] zero
  output logic [KIND_W-1:0]     out_tuser   // [1:0] kind
);

  cbnd_cmd_t cmd;
  cbnd_sts_t sts;

  // Handshake sequencing: capture, optional division, commit
  cbnd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Walk state, divider unit, configuration and output register
  cbnd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[design/cbnd_div.sv]
module cbnd_div
  import cbnd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 busy,
  output logic [DIV_W-1:0]     quot
);

  logic                 busy_r, busy_nxt;
  logic [2:0]           cnt_r, cnt_nxt;
  logic [DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [DSR_W-1:0]     dsr_r, dsr_nxt;
  logic [DIV_W-1:0]     quot_r, quot_nxt;
  logic [DSR_W-1:0]     rem_ext;
  logic [DSR_W-1:0]     diff;
  logic                 fits;

  assign rem_ext = {{(DSR_W-DIVISOR_W){1'b0}}, rem_r};
  assign fits    = rem_ext >= dsr_r;
  assign diff    = rem_ext - dsr_r;

  // One restoring step per cycle, quotient MSB first
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quot_nxt = quot_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 3'(DIV_W - 1);
      rem_nxt  = FREQ_BASE;
      dsr_nxt  = {divisor, {(DIV_W-1){1'b0}}};
      quot_nxt = '0;
    end else if (busy_r) begin
      quot_nxt = {quot_r[DIV_W-2:0], fits};
      rem_nxt  = fits ? diff[DIVISOR_W-1:0] : rem_r;
      dsr_nxt  = dsr_r >> 1;
      cnt_nxt  = cnt_r - 3'd1;
      if (cnt_r == 3'd0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
    quot_r <= quot_nxt;
  end

  assign busy = busy_r;
  assign quot = quot_r;

  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy_r |=> busy_r ##7 busy_r ##1 !busy_r)
    else $error("divider did not finish in eight steps");

endmodule

[design/cbnd_dp.sv]
module cbnd_dp
  import cbnd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_wdata,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  cbnd_cmd_t             cmd,
  output cbnd_sts_t             sts,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [KIND_W-1:0]     out_tuser
);

  localparam logic [2:0] PH_IDLE        = 3'd0;
  localparam logic [2:0] PH_ROOT        = 3'd1;
  localparam logic [2:0] PH_GROUP_CAPS  = 3'd2;
  localparam logic [2:0] PH_GROUP_COUNT = 3'd3;
  localparam logic [2:0] PH_WIDGET      = 3'd4;
  localparam logic [2:0] PH_SET_BEEP    = 3'd5;
  localparam int         NODE_PAD       = NODE_W - CUR_W;

  logic              ovr_en_r, ovr_en_nxt;
  logic [NODE_W-1:0] ovr_node_r, ovr_node_nxt;

  logic [2:0]        phase_r, phase_nxt;
  logic [CUR_W-1:0]  cur_r, cur_nxt;
  logic [CUR_W-1:0]  end_r, end_nxt;
  logic [DIV_W-1:0]  bdiv_r, bdiv_nxt;
  logic [NODE_W-1:0] found_r, found_nxt;

  logic              cap_op_r;
  logic [FREQ_W-1:0] cap_freq_r;
  logic [RESP_W-1:0] cap_resp_r;
  logic              cap_ok_r;

  logic              out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] out_kind_r;
  logic [VERB_W-1:0] out_verb_r;
  logic [NODE_W-1:0] out_node_r;
  logic [DIV_W-1:0]  out_div_r;

  logic [KIND_W-1:0] kind_nxt;
  logic [VERB_W-1:0] verb_nxt;
  logic [NODE_W-1:0] node_nxt;

  logic [FREQ_W-1:0] in_freq;
  logic              div_busy;
  logic [DIV_W-1:0]  div_quot;
  logic [DIV_W-1:0]  req_div;
  logic [CUR_W-1:0]  lr_cur, lr_end, cur_inc;

  assign in_freq = in_tdata[FREQ_W-1:0];

  cbnd_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .divisor (in_freq[DIVISOR_W-1:0]),
    .busy    (div_busy),
    .quot    (div_quot)
  );

  assign sts.need_div = (in_tuser == OP_REQUEST) && (phase_r == PH_IDLE) &&
                        (in_freq >= FREQ_LOW) && (in_freq <= FREQ_HIGH);
  assign sts.div_busy = div_busy;
  assign sts.out_free = !out_valid_r || out_tready;

  // Configuration writes
  always_comb begin
    ovr_en_nxt   = ovr_en_r;
    ovr_node_nxt = ovr_node_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_OVERRIDE_ENABLE: ovr_en_nxt   = cfg_wdata[0];
        CFG_OVERRIDE_NODE:   ovr_node_nxt = cfg_wdata;
        default:             ovr_en_nxt   = ovr_en_r;
      endcase
    end
  end

  always_comb begin
    if (cap_freq_r == '0) begin
      req_div = '0;
    end else if (cap_freq_r > FREQ_HIGH) begin
      req_div = DIV_FAST;
    end else if (cap_freq_r < FREQ_LOW) begin
      req_div = DIV_MAX;
    end else begin
      req_div = div_quot;
    end
  end

  assign lr_cur  = {1'b0, cap_resp_r[23:16]};
  assign lr_end  = lr_cur + {1'b0, cap_resp_r[7:0]};
  assign cur_inc = cur_r + 9'd1;

  // One walk step for the captured item
  always_comb begin
    phase_nxt = phase_r;
    cur_nxt   = cur_r;
    end_nxt   = end_r;
    bdiv_nxt  = bdiv_r;
    found_nxt = found_r;
    kind_nxt  = K_IGNORE;
    verb_nxt  = '0;
    node_nxt  = '0;
    if (cap_op_r == OP_REQUEST) begin
      if (phase_r == PH_IDLE) begin
        bdiv_nxt = req_div;
        if (ovr_en_r) begin
          if (ovr_node_r == '0) begin
            kind_nxt = K_FAILED;
          end else begin
            found_nxt = ovr_node_r;
            phase_nxt = PH_SET_BEEP;
            kind_nxt  = K_VERB;
            verb_nxt  = make_verb(ovr_node_r, V_SET_BEEP, req_div);
          end
        end else begin
          phase_nxt = PH_ROOT;
          kind_nxt  = K_VERB;
          verb_nxt  = make_verb('0, V_GET_PARAMS, P_NODE_COUNT);
        end
      end
    end else begin
      unique case (phase_r)
        PH_ROOT: begin
          if (!cap_ok_r) begin
            kind_nxt = K_FAILED;
          end else begin
            cur_nxt = lr_cur;
            end_nxt = lr_end;
            if (lr_cur < lr_end) begin
              phase_nxt = PH_GROUP_CAPS;
              kind_nxt  = K_VERB;
              verb_nxt  = make_verb({{NODE_PAD{1'b0}}, lr_cur}, V_GET_PARAMS, P_GROUP_CAPS);
            end else begin
              kind_nxt = K_FAILED;
            end
          end
        end
        PH_GROUP_CAPS: begin
          if (cap_ok_r && cap_resp_r[GROUP_BEEP_BIT]) begin
            phase_nxt = PH_GROUP_COUNT;
            kind_nxt  = K_VERB;
            verb_nxt  = make_verb({{NODE_PAD{1'b0}}, cur_r}, V_GET_PARAMS, P_NODE_COUNT);
          end else begin
            // no beep generator here: try the next group
            cur_nxt = cur_inc;
            if (cur_inc < end_r) begin
              kind_nxt = K_VERB;
              verb_nxt = make_verb({{NODE_PAD{1'b0}}, cur_inc}, V_GET_PARAMS, P_GROUP_CAPS);
            end else begin
              kind_nxt = K_FAILED;
            end
          end
        end
        PH_GROUP_COUNT: begin
          if (!cap_ok_r) begin
            kind_nxt = K_FAILED;
          end else begin
            cur_nxt = lr_cur;
            end_nxt = lr_end;
            if (lr_cur < lr_end) begin
              phase_nxt = PH_WIDGET;
              kind_nxt  = K_VERB;
              verb_nxt  = make_verb({{NODE_PAD{1'b0}}, lr_cur}, V_GET_PARAMS, P_WIDGET_CAPS);
            end else begin
              kind_nxt = K_FAILED;
            end
          end
        end
        PH_WIDGET: begin
          if (!cap_ok_r) begin
            kind_nxt = K_FAILED;
          end else if (cap_resp_r[23:20] == WIDGET_BEEP) begin
            found_nxt = {{NODE_PAD{1'b0}}, cur_r};
            phase_nxt = PH_SET_BEEP;
            kind_nxt  = K_VERB;
            verb_nxt  = make_verb({{NODE_PAD{1'b0}}, cur_r}, V_SET_BEEP, bdiv_r);
          end else begin
            cur_nxt = cur_inc;
            if (cur_inc < end_r) begin
              kind_nxt = K_VERB;
              verb_nxt = make_verb({{NODE_PAD{1'b0}}, cur_inc}, V_GET_PARAMS, P_WIDGET_CAPS);
            end else begin
              kind_nxt = K_FAILED;
            end
          end
        end
        PH_SET_BEEP: begin
          kind_nxt = K_DONE;
          node_nxt = found_r;
        end
        default: begin
          kind_nxt = K_IGNORE;
        end
      endcase
    end
    if (kind_nxt == K_DONE || kind_nxt == K_FAILED) begin
      phase_nxt = PH_IDLE;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovr_en_r    <= 1'b0;
      ovr_node_r  <= '0;
      phase_r     <= PH_IDLE;
      cur_r       <= '0;
      end_r       <= '0;
      bdiv_r      <= '0;
      found_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ovr_en_r    <= ovr_en_nxt;
      ovr_node_r  <= ovr_node_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.commit) begin
        phase_r <= phase_nxt;
        cur_r   <= cur_nxt;
        end_r   <= end_nxt;
        bdiv_r  <= bdiv_nxt;
        found_r <= found_nxt;
      end
    end
    if (cmd.capture) begin
      cap_op_r   <= in_tuser;
      cap_freq_r <= in_freq;
      cap_resp_r <= in_tdata[FREQ_W +: RESP_W];
      cap_ok_r   <= in_tdata[FREQ_W + RESP_W];
    end
    if (cmd.commit) begin
      out_kind_r <= kind_nxt;
      out_verb_r <= verb_nxt;
      out_node_r <= node_nxt;
      out_div_r  <= bdiv_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {{(OUT_DATA_W-VERB_W-NODE_W-DIV_W){1'b0}},
                       out_div_r, out_node_r, out_verb_r};

  a_done_from_set_beep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && kind_nxt == K_DONE |-> phase_r == PH_SET_BEEP)
    else $error("done result outside the set-beep step");

  a_commit_not_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !div_busy)
    else $error("step committed while the divider is busy");

  a_commit_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.out_free ##1 out_valid_r)
    else $error("step committed over an unread result");

endmodule

[design/cbnd_ctrl.sv]
module cbnd_ctrl
  import cbnd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  cbnd_sts_t sts,
  output cbnd_cmd_t cmd
);

  localparam logic [1:0] S_IN     = 2'd0;
  localparam logic [1:0] S_DIV    = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       accept;

  assign in_tready     = (state_r == S_IN);
  assign accept        = in_tvalid && in_tready;
  assign cmd.capture   = accept;
  assign cmd.div_start = accept && sts.need_div;
  assign cmd.commit    = (state_r == S_COMMIT) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IN: begin
        if (accept) begin
          state_nxt = sts.need_div ? S_DIV : S_COMMIT;
        end
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          state_nxt = S_IN;
        end
      end
      default: begin
        state_nxt = S_IN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IN;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
